// ----- hw/rtl/hss_pkg.sv -----
// ----------------------------------------------------------------------------
// hss_pkg
// Shared codes, widths, configuration layout and the half-step coil table
// of the stepper half-step sequencer.
// ----------------------------------------------------------------------------
package hss_pkg;

   localparam int MAX_REV_STEPS_DEF = 4096;
   localparam int DELAY_BITS_DEF    = 20;

   localparam int ACTION_BITS   = 2;
   localparam int COUNT_BITS    = 16;
   localparam int COIL_BITS     = 4;
   localparam int LEFT_BITS     = 16;
   localparam int REV_CFG_BITS  = 13;
   localparam int DELAY_CFG_BITS = 20;
   localparam int CSR_DATA_BITS = 20;
   localparam int CSR_INDEX_BITS = 2;
   localparam int SEQ_BITS      = 3;

   localparam logic [ACTION_BITS-1:0] ACT_TICK = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_MOVE = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_OFF  = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_REV_STEPS    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DELAY_TICKS  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IDLE_PATTERN = 2'd2;

   localparam logic [REV_CFG_BITS-1:0]   REV_STEPS_RST    = 13'd4096;
   localparam logic [DELAY_CFG_BITS-1:0] DELAY_TICKS_RST  = 20'd1000;
   localparam logic [COIL_BITS-1:0]      IDLE_PATTERN_RST = 4'd0;

   localparam logic [COIL_BITS-1:0] HALF_STEP_TABLE [0:7] = '{
      4'h1, 4'h5, 4'h4, 4'h6, 4'h2, 4'hA, 4'h8, 4'h9
   };

   typedef struct packed {
      logic [REV_CFG_BITS-1:0]   rev_steps;
      logic [DELAY_CFG_BITS-1:0] delay_ticks;
      logic [COIL_BITS-1:0]      idle_pattern;
   } hss_cfg_type;

endpackage

// ----- hw/rtl/hss_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// hss_cfg_regs
// Configuration registers and the clamped steps-per-revolution value.
// ----------------------------------------------------------------------------
module hss_cfg_regs #(
   parameter int MAX_REV_STEPS = hss_pkg::MAX_REV_STEPS_DEF,
   parameter int REV_BITS      = $clog2(MAX_REV_STEPS) + 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [hss_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [hss_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output hss_pkg::hss_cfg_type                cfg,
   output logic [REV_BITS-1:0]                 rev_eff
);

   hss_pkg::hss_cfg_type cfg_ff;
   hss_pkg::hss_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            hss_pkg::CSR_REV_STEPS: begin
               cfg_in.rev_steps = csr_wdata[hss_pkg::REV_CFG_BITS-1:0];
            end
            hss_pkg::CSR_DELAY_TICKS: begin
               cfg_in.delay_ticks = csr_wdata[hss_pkg::DELAY_CFG_BITS-1:0];
            end
            hss_pkg::CSR_IDLE_PATTERN: begin
               cfg_in.idle_pattern = csr_wdata[hss_pkg::COIL_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rev_steps    <= hss_pkg::REV_STEPS_RST;
         cfg_ff.delay_ticks  <= hss_pkg::DELAY_TICKS_RST;
         cfg_ff.idle_pattern <= hss_pkg::IDLE_PATTERN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // clamp to one step minimum and to the supported maximum
   always_comb begin
      if (cfg_ff.rev_steps == '0) begin
         rev_eff = REV_BITS'(1);
      end else if (32'(cfg_ff.rev_steps) > 32'(MAX_REV_STEPS)) begin
         rev_eff = REV_BITS'(MAX_REV_STEPS);
      end else begin
         rev_eff = REV_BITS'(cfg_ff.rev_steps);
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/hss_step_core.sv -----
// ----------------------------------------------------------------------------
// hss_step_core
// Motor state registers and the per-item update: move load, deactivate,
// delay countdown, position wrap and coil table lookup.
// ----------------------------------------------------------------------------
module hss_step_core #(
   parameter int POS_BITS   = $clog2(hss_pkg::MAX_REV_STEPS_DEF),
   parameter int REV_BITS   = POS_BITS + 1,
   parameter int DELAY_BITS = hss_pkg::DELAY_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              update,
   input  logic [hss_pkg::ACTION_BITS-1:0]   action,
   input  logic signed [hss_pkg::COUNT_BITS-1:0] step_count,
   input  hss_pkg::hss_cfg_type              cfg,
   input  logic [REV_BITS-1:0]               rev_eff,
   output logic [hss_pkg::COIL_BITS-1:0]     coil_nxt,
   output logic [POS_BITS-1:0]               pos_nxt,
   output logic [hss_pkg::LEFT_BITS-1:0]     left_nxt
);

   logic [POS_BITS-1:0]               pos_ff,  pos_in;
   logic [hss_pkg::LEFT_BITS-1:0]     left_ff, left_in;
   logic                              dir_ff,  dir_in;
   logic [DELAY_BITS-1:0]             wait_ff, wait_in;
   logic [hss_pkg::COIL_BITS-1:0]     coil_ff, coil_in;

   logic [REV_BITS-1:0]               pos_inc;
   logic [REV_BITS-1:0]               rev_last;
   logic [POS_BITS-1:0]               pos_step;
   logic [hss_pkg::DELAY_CFG_BITS-1:0] delay_dec;
   logic [DELAY_BITS-1:0]             wait_reload;

   assign pos_inc   = {1'b0, pos_ff} + REV_BITS'(1);
   assign rev_last  = rev_eff - REV_BITS'(1);
   assign delay_dec = cfg.delay_ticks - hss_pkg::DELAY_CFG_BITS'(1);
   assign wait_reload = (cfg.delay_ticks == '0) ? '0 : DELAY_BITS'(delay_dec);

   always_comb begin
      if (!dir_ff) begin
         pos_step = (pos_inc >= rev_eff) ? '0 : pos_inc[POS_BITS-1:0];
      end else if (pos_ff == '0 || {1'b0, pos_ff} >= rev_eff) begin
         pos_step = rev_last[POS_BITS-1:0];
      end else begin
         pos_step = pos_ff - POS_BITS'(1);
      end
   end

   always_comb begin
      pos_in  = pos_ff;
      left_in = left_ff;
      dir_in  = dir_ff;
      wait_in = wait_ff;
      coil_in = coil_ff;
      unique case (action)
         hss_pkg::ACT_MOVE: begin
            if (step_count < 0) begin
               left_in = hss_pkg::LEFT_BITS'(-step_count);
               dir_in  = 1'b1;
            end else begin
               left_in = hss_pkg::LEFT_BITS'(step_count);
               dir_in  = (step_count == '0);
            end
            wait_in = '0;
         end
         hss_pkg::ACT_OFF: begin
            coil_in = cfg.idle_pattern;
            left_in = '0;
            wait_in = '0;
         end
         hss_pkg::ACT_TICK: begin
            if (left_ff != '0) begin
               if (wait_ff == '0) begin
                  pos_in  = pos_step;
                  coil_in = hss_pkg::HALF_STEP_TABLE[pos_step[hss_pkg::SEQ_BITS-1:0]];
                  left_in = left_ff - hss_pkg::LEFT_BITS'(1);
                  wait_in = wait_reload;
               end else begin
                  wait_in = wait_ff - DELAY_BITS'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         left_ff <= '0;
         dir_ff  <= 1'b0;
         wait_ff <= '0;
         coil_ff <= '0;
      end else if (update) begin
         pos_ff  <= pos_in;
         left_ff <= left_in;
         dir_ff  <= dir_in;
         wait_ff <= wait_in;
         coil_ff <= coil_in;
      end
   end

   assign coil_nxt = coil_in;
   assign pos_nxt  = pos_in;
   assign left_nxt = left_in;

endmodule

// ----- hw/rtl/stepper_half_step_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// stepper_half_step_sequencer_unit
// Half-step sequencer for a four-coil unipolar stepper: moves, ticks and
// deactivate commands in, one status transfer out per command.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tuser: action; tdata: step_count
//   rsp      out  rsp_tvalid/rsp_tready  tdata: coil, position, busy, remaining
//   csr      in   csr_wr_en              csr_index, csr_wdata
//
// One command per cycle sustained unless rsp stalls; rsp valid follows a req
// transfer via the input register, then the state update into the result register.
// Reset is synchronous; motor state clears and registers take their defaults.
// A stalled rsp holds its result while one more command waits in the input
// register; req_tready drops only when both stages are full.
// ----------------------------------------------------------------------------
module stepper_half_step_sequencer_unit #(
   parameter int MAX_REV_STEPS = hss_pkg::MAX_REV_STEPS_DEF,
   parameter int DELAY_BITS    = hss_pkg::DELAY_BITS_DEF,
   parameter int POS_BITS      = $clog2(MAX_REV_STEPS),
   parameter int RSP_BITS      = ((hss_pkg::COIL_BITS + POS_BITS + 1
                                   + hss_pkg::LEFT_BITS + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [hss_pkg::COUNT_BITS-1:0]     req_tdata,  // step_count
   input  logic [hss_pkg::ACTION_BITS-1:0]    req_tuser,  // action
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [RSP_BITS-1:0]                rsp_tdata,  // coil_pattern, position,
                                                          // busy_res, remaining, zero pad
   input  logic                               csr_wr_en,
   input  logic [hss_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [hss_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int REV_BITS  = POS_BITS + 1;

   hss_pkg::hss_cfg_type                cfg;
   logic [REV_BITS-1:0]                 rev_eff;

   logic                                in_valid_ff;
   logic [hss_pkg::ACTION_BITS-1:0]     in_action_ff;
   logic [hss_pkg::COUNT_BITS-1:0]      in_count_ff;

   logic                                out_valid_ff;
   logic [hss_pkg::COIL_BITS-1:0]       out_coil_ff;
   logic [POS_BITS-1:0]                 out_pos_ff;
   logic [hss_pkg::LEFT_BITS-1:0]       out_left_ff;

   logic [hss_pkg::COIL_BITS-1:0]       coil_nxt;
   logic [POS_BITS-1:0]                 pos_nxt;
   logic [hss_pkg::LEFT_BITS-1:0]       left_nxt;

   logic                                advance;
   logic                                req_xfer;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   hss_cfg_regs #(
      .MAX_REV_STEPS (MAX_REV_STEPS),
      .REV_BITS      (REV_BITS)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .rev_eff   (rev_eff)
   );

   hss_step_core #(
      .POS_BITS   (POS_BITS),
      .REV_BITS   (REV_BITS),
      .DELAY_BITS (DELAY_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .update     (advance),
      .action     (in_action_ff),
      .step_count (in_count_ff),
      .cfg        (cfg),
      .rev_eff    (rev_eff),
      .coil_nxt   (coil_nxt),
      .pos_nxt    (pos_nxt),
      .left_nxt   (left_nxt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_action_ff <= req_tuser;
         in_count_ff  <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_coil_ff <= coil_nxt;
         out_pos_ff  <= pos_nxt;
         out_left_ff <= left_nxt;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_BITS'({out_left_ff, (out_left_ff != '0), out_pos_ff, out_coil_ff});

endmodule

// ----- bench/stepper_half_step_sequencer_unit_tb.sv -----
// ----------------------------------------------------------------------------
// stepper_half_step_sequencer_unit_tb
// Self-checking bench for the half-step sequencer. Commands (tick, move,
// deactivate and the unused action code) go in on the req stream. A
// scoreboard keeps its own copy of the motor state and the settings and
// predicts one status word per accepted command. Each rsp transfer is
// compared field by field with the oldest prediction.
// The run starts with a directed sequence of wraps, extreme counts and
// ignored commands. It then goes through a series of register settings,
// including zero and oversized revolutions and the smallest and largest
// delays, each followed by random command streams. Both sides idle at
// random, with one phase free of idling and one long receiver hold-off
// that backs up the input.
// ----------------------------------------------------------------------------
module stepper_half_step_sequencer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hss_pkg::*;

   localparam int POS_W = 12;
   localparam int RSP_W = ((COIL_BITS + POS_W + 1 + LEFT_BITS + 7) / 8) * 8;
   localparam int STAT_W = COIL_BITS + POS_W + 1 + LEFT_BITS;
   localparam logic [ACTION_BITS-1:0] ACT_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_CYCLES = 150;
   localparam int PHASE_ITEMS = 135;
   localparam int NUM_SETTINGS = 8;

   typedef struct packed {
      logic [LEFT_BITS-1:0] remaining;
      logic                 busy_res;
      logic [POS_W-1:0]     position;
      logic [COIL_BITS-1:0] coil_pattern;
   } motor_status_t;

   class hss_scoreboard;
      logic [REV_CFG_BITS-1:0]   rev_cfg;
      logic [DELAY_CFG_BITS-1:0] delay_cfg;
      logic [COIL_BITS-1:0]      idle_cfg;
      logic [POS_W-1:0]          pos;
      logic [LEFT_BITS-1:0]      left;
      logic                      backward;
      logic [DELAY_CFG_BITS-1:0] wait_cnt;
      logic [COIL_BITS-1:0]      coil;
      logic [COIL_BITS-1:0]      coil_seq [8];
      motor_status_t             status_q [$];
      int                        errors;
      int                        commands;
      int                        checked;

      function new();
         coil_seq = '{4'h1, 4'h5, 4'h4, 4'h6, 4'h2, 4'hA, 4'h8, 4'h9};
         rev_cfg = 13'd4096;
         delay_cfg = 20'd1000;
         idle_cfg = 4'd0;
         pos = '0;
         left = '0;
         backward = 1'b0;
         wait_cnt = '0;
         coil = '0;
         errors = 0;
         commands = 0;
         checked = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            CSR_REV_STEPS:    rev_cfg = data[REV_CFG_BITS-1:0];
            CSR_DELAY_TICKS:  delay_cfg = data[DELAY_CFG_BITS-1:0];
            CSR_IDLE_PATTERN: idle_cfg = data[COIL_BITS-1:0];
            default: ;
         endcase
      endfunction

      function void advance_one();
         int r;
         int p;
         r = (rev_cfg == 0) ? 1 : ((rev_cfg > MAX_REV_STEPS_DEF) ? MAX_REV_STEPS_DEF : rev_cfg);
         p = pos;
         if (!backward)
            p = (p + 1 >= r) ? 0 : p + 1;
         else
            p = (p == 0 || p >= r) ? r - 1 : p - 1;
         pos = p[POS_W-1:0];
         coil = coil_seq[pos[2:0]];
      endfunction

      function void note_command(logic [ACTION_BITS-1:0] act, logic [COUNT_BITS-1:0] cnt);
         motor_status_t exp;
         case (act)
            ACT_MOVE: begin
               if (cnt[COUNT_BITS-1]) begin
                  left = -cnt;
                  backward = 1'b1;
               end else begin
                  left = cnt;
                  backward = (cnt == 0);
               end
               wait_cnt = '0;
            end
            ACT_OFF: begin
               coil = idle_cfg;
               left = '0;
               wait_cnt = '0;
            end
            ACT_TICK: begin
               if (left != 0) begin
                  if (wait_cnt == 0) begin
                     advance_one();
                     left = left - 1'b1;
                     wait_cnt = (delay_cfg == 0) ? '0 : delay_cfg - 1'b1;
                  end else begin
                     wait_cnt = wait_cnt - 1'b1;
                  end
               end
            end
            default: ;
         endcase
         exp.coil_pattern = coil;
         exp.position = pos;
         exp.busy_res = (left != 0);
         exp.remaining = left;
         status_q.push_back(exp);
         commands++;
      endfunction

      function void check_status(logic [RSP_W-1:0] word);
         motor_status_t exp;
         motor_status_t got;
         checked++;
         if (status_q.size() == 0) begin
            $error("status transfer with no command outstanding: %h", word);
            errors++;
            return;
         end
         exp = status_q.pop_front();
         got = word[STAT_W-1:0];
         if (got.coil_pattern !== exp.coil_pattern) begin
            $error("coil_pattern: expected %h, got %h", exp.coil_pattern, got.coil_pattern);
            errors++;
         end
         if (got.position !== exp.position) begin
            $error("position: expected %0d, got %0d", exp.position, got.position);
            errors++;
         end
         if (got.busy_res !== exp.busy_res) begin
            $error("busy_res: expected %b, got %b", exp.busy_res, got.busy_res);
            errors++;
         end
         if (got.remaining !== exp.remaining) begin
            $error("remaining: expected %0d, got %0d", exp.remaining, got.remaining);
            errors++;
         end
         if (word[RSP_W-1:STAT_W] !== '0) begin
            $error("pad: expected 0, got %h", word[RSP_W-1:STAT_W]);
            errors++;
         end
      endfunction

      function int pending();
         return status_q.size();
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [COUNT_BITS-1:0]     req_tdata = '0;   // step_count
   logic [ACTION_BITS-1:0]    req_tuser = '0;   // action
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_W-1:0]          rsp_tdata;        // coil_pattern, position, busy_res,
                                                // remaining, zero pad
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   logic                      idle_on = 1'b1;
   logic                      hold_active = 1'b0;
   int                        cycle_count = 0;
   event                      hold_off_ev;
   hss_scoreboard             sb;

   stepper_half_step_sequencer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[stepper_half_step_sequencer_unit] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_status(rsp_tdata);
      if (reset || hold_active)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= !idle_on || ($urandom_range(99) >= 20);
   end

   // hold off the receiver so the block fills and stalls req
   always begin
      @(hold_off_ev);
      @(posedge clock);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active <= 1'b0;
   end

   task automatic send_command(input logic [ACTION_BITS-1:0] act,
                               input logic [COUNT_BITS-1:0] cnt);
      int gaps;
      gaps = 0;
      while (idle_on && $urandom_range(99) < 20)
         gaps++;
      if (gaps > 0) begin
         req_tvalid <= 1'b0;
         repeat (gaps) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= cnt;
      do
         @(posedge clock);
      while (!req_tready);
      sb.note_command(act, cnt);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [CSR_DATA_BITS-1:0] rev,
                                input logic [CSR_DATA_BITS-1:0] delay,
                                input logic [CSR_DATA_BITS-1:0] idle);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_REV_STEPS;
      csr_wdata <= rev;
      @(posedge clock);
      sb.set_reg(CSR_REV_STEPS, rev);
      csr_index <= CSR_DELAY_TICKS;
      csr_wdata <= delay;
      @(posedge clock);
      sb.set_reg(CSR_DELAY_TICKS, delay);
      csr_index <= CSR_IDLE_PATTERN;
      csr_wdata <= idle;
      @(posedge clock);
      sb.set_reg(CSR_IDLE_PATTERN, idle);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [COUNT_BITS-1:0] pick_count();
      int unsigned sel;
      int          mag;
      sel = $urandom_range(99);
      if (sel < 65)
         mag = $urandom_range(12, 1);
      else if (sel < 80)
         mag = $urandom_range(400);
      else if (sel < 90)
         return COUNT_BITS'($urandom);
      else begin
         case ($urandom_range(2))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return 16'h0000;
         endcase
      end
      return $urandom_range(1) ? COUNT_BITS'(-mag) : COUNT_BITS'(mag);
   endfunction

   task automatic send_random();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 62)
         send_command(ACT_TICK, COUNT_BITS'($urandom));
      else if (sel < 78)
         send_command(ACT_MOVE, pick_count());
      else if (sel < 88)
         send_command(ACT_OFF, COUNT_BITS'($urandom));
      else if (sel < 93)
         send_command(ACT_SPARE, COUNT_BITS'($urandom));
      else
         send_command(ACT_TICK, '0);
   endtask

   logic [CSR_DATA_BITS-1:0] set_rev   [NUM_SETTINGS] =
      '{20'd0, 20'd8191, 20'd4096, 20'd1, 20'd5, 20'd4097, 20'd13, 20'd100};
   logic [CSR_DATA_BITS-1:0] set_delay [NUM_SETTINGS] =
      '{20'd1, 20'd2, 20'd1, 20'd3, 20'd1, 20'd0, 20'd1048575, 20'd4};
   logic [CSR_DATA_BITS-1:0] set_idle  [NUM_SETTINGS] =
      '{20'h5, 20'hA, 20'h0, 20'h3, 20'h9, 20'hC, 20'h6, 20'hF};

   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: wraps at 4096, long delay, ignored commands
      send_command(ACT_TICK, 16'h0000);
      send_command(ACT_MOVE, 16'hFFFF);
      send_command(ACT_TICK, 16'hFFFF);
      send_command(ACT_MOVE, 16'h0003);
      send_command(ACT_TICK, 16'h0000);
      send_command(ACT_TICK, 16'h0000);
      send_command(ACT_SPARE, 16'h1234);
      send_command(ACT_MOVE, 16'h0000);
      send_command(ACT_TICK, 16'h0000);
      send_command(ACT_MOVE, 16'h8000);
      send_command(ACT_TICK, 16'h0000);
      send_command(ACT_OFF, 16'h5A5A);
      send_command(ACT_MOVE, 16'h7FFF);
      send_command(ACT_TICK, 16'h0000);
      send_command(ACT_OFF, 16'h0000);
      drain();

      // zero delay, wraps in both directions over an 8-step revolution
      apply_setting(20'd8, 20'd0, 20'hF);
      send_command(ACT_MOVE, 16'hFFFE);
      send_command(ACT_TICK, 16'h0000);
      send_command(ACT_TICK, 16'h0000);
      send_command(ACT_MOVE, 16'h0002);
      send_command(ACT_TICK, 16'h0000);
      send_command(ACT_TICK, 16'h0000);
      send_command(ACT_OFF, 16'h0000);
      drain();

      for (int s = 0; s < NUM_SETTINGS; s++) begin
         apply_setting(set_rev[s], set_delay[s], set_idle[s]);
         idle_on <= (s != 4);
         if (s == 2)
            -> hold_off_ev;
         for (int i = 0; i < PHASE_ITEMS; i++)
            send_random();
         drain();
      end

      repeat (8) @(posedge clock);
      $display("Covered %0d commands and %0d status transfers over %0d register settings,",
               sb.commands, sb.checked, NUM_SETTINGS + 2);
      $display("with wraps, extreme counts, idle-free stretches and a %0d-cycle rsp hold-off.",
               HOLD_CYCLES);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("[stepper_half_step_sequencer_unit] OK");
      else
         $display("[stepper_half_step_sequencer_unit] ERROR");
      $finish;
   end

endmodule

// ----- stepper_half_step_sequencer_unit.f -----
hw/rtl/hss_pkg.sv
hw/rtl/hss_cfg_regs.sv
hw/rtl/hss_step_core.sv
hw/rtl/stepper_half_step_sequencer_unit.sv
bench/stepper_half_step_sequencer_unit_tb.sv
